FILE: src/lar_pkg.sv
// shared constants and types for the look-at rotation basis block
package lar_pkg;

    // defaults for the top-level parameters
    localparam int DEF_IN_WIDTH  = 32;
    localparam int DEF_FRAC_BITS = 30;

    // threshold register
    localparam int              THR_W     = 31;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    // result word layout
    localparam int OUT_W   = 32;
    localparam int N_ENTRY = 9;

    // normalizer internals: mantissa band [2^30, 2^31), 32-bit root, 64-bit sum
    localparam int MANT_W = 31;
    localparam int ROOT_W = 32;
    localparam int SUM_W  = 64;

    // front to back queue
    localparam int QUEUE_DEPTH = 4;

    // result flags, packed so the last field lands in bit 0
    typedef struct packed {
        logic degenerate;
        logic used_alternate_up;
    } lar_flags_t;

    localparam int FLAG_W = $bits(lar_flags_t);

endpackage

FILE: src/look_at_rotation_basis.sv
// look-at rotation basis top level: threshold register, front end, queue and back end
//
//  channel   dir   handshake                 payload
//  s_        in    s_tvalid / s_tready       s_tdata: gaze_x, gaze_y, gaze_z
//  m_        out   m_tvalid / m_tready       m_tdata: 9 matrix entries, m_tuser: 2 flags
//  cfg_      in    cfg_valid / cfg_ready     cfg_data: parallel_threshold
//
// one word accepted and one result delivered per cycle while m_tready is high
// each of the three normalizers produces one root bit per stage, then one
// quotient bit per stage
// reset clears all valids and loads the threshold with 1
// m_tready low freezes the back pipeline; the four-word queue and the input register
// take five more words, then s_tready drops until m_tready returns
module look_at_rotation_basis #(
    parameter int IN_WIDTH  = lar_pkg::DEF_IN_WIDTH,
    parameter int FRAC_BITS = lar_pkg::DEF_FRAC_BITS
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // gaze_x, gaze_y, gaze_z, zero padded to bytes
    input  logic [((3*IN_WIDTH+7)/8)*8-1:0]            s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // right_x, right_y, right_z, vert_x, vert_y, vert_z, axis_x, axis_y, axis_z
    output logic [lar_pkg::N_ENTRY*lar_pkg::OUT_W-1:0] m_tdata,
    // used_alternate_up, degenerate
    output logic [lar_pkg::FLAG_W-1:0]                 m_tuser,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [lar_pkg::THR_W-1:0]                  cfg_data
);
    import lar_pkg::*;

    localparam int S_DATA_W = ((3 * IN_WIDTH + 7) / 8) * 8;
    localparam int Q_DATA_W = 3 + 3 * IN_WIDTH + 1;

    logic [THR_W-1:0]         thr_reg;
    logic                     f_valid, f_ready, f_degen;
    logic [2:0]               f_neg, q_neg;
    logic [2:0][IN_WIDTH-1:0] f_mag, q_mag;
    logic                     q_valid, q_pop, q_degen;
    logic [Q_DATA_W-1:0]      q_out;
    lar_flags_t               flags;

    // threshold register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= cfg_data;
        end
    end

    lar_front #(
        .IN_WIDTH(IN_WIDTH),
        .S_DATA_W(S_DATA_W)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .f_valid (f_valid),
        .f_ready (f_ready),
        .f_neg   (f_neg),
        .f_mag   (f_mag),
        .f_degen (f_degen)
    );

    lar_queue #(
        .DATA_W(Q_DATA_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_data  ({f_neg, f_mag, f_degen}),
        .out_valid(q_valid),
        .out_pop  (q_pop),
        .out_data (q_out)
    );

    assign {q_neg, q_mag, q_degen} = q_out;

    lar_back #(
        .IN_WIDTH (IN_WIDTH),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .threshold(thr_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_neg    (q_neg),
        .q_mag    (q_mag),
        .q_degen  (q_degen),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (m_tdata),
        .m_flags  (flags)
    );

    assign m_tuser = flags;

endmodule

FILE: src/lar_front.sv
// front end: input register, sign/magnitude split and zero-gaze detect
module lar_front #(
    parameter int IN_WIDTH = lar_pkg::DEF_IN_WIDTH,
    parameter int S_DATA_W = ((3 * IN_WIDTH + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_DATA_W-1:0]      s_tdata,
    output logic                     f_valid,
    input  logic                     f_ready,
    output logic [2:0]               f_neg,
    output logic [2:0][IN_WIDTH-1:0] f_mag,
    output logic                     f_degen
);
    import lar_pkg::*;

    logic                     f_valid_reg;
    logic [2:0]               f_neg_reg;
    logic [2:0][IN_WIDTH-1:0] f_mag_reg;
    logic                     f_degen_reg;

    logic [2:0]               neg_next;
    logic [2:0][IN_WIDTH-1:0] mag_next;
    logic [IN_WIDTH-1:0]      comp;

    // split each component into sign and magnitude
    always_comb begin
        comp = '0;
        for (int k = 0; k < 3; k++) begin
            comp        = s_tdata[k*IN_WIDTH +: IN_WIDTH];
            neg_next[k] = comp[IN_WIDTH-1];
            mag_next[k] = comp[IN_WIDTH-1] ? (~comp + IN_WIDTH'(1)) : comp;
        end
    end

    assign s_tready = !f_valid_reg || f_ready;

    // input register, refilled when it is empty or the queue takes the held word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (s_tready) begin
            f_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            f_neg_reg   <= neg_next;
            f_mag_reg   <= mag_next;
            f_degen_reg <= (mag_next[0] == '0) && (mag_next[1] == '0) && (mag_next[2] == '0);
        end
    end

    assign f_valid = f_valid_reg;
    assign f_neg   = f_neg_reg;
    assign f_mag   = f_mag_reg;
    assign f_degen = f_degen_reg;

endmodule

FILE: src/lar_queue.sv
// short word queue between front and back
module lar_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = lar_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_pop,
    output logic [DATA_W-1:0] out_data
);
    import lar_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_data  = mem[rd_ptr_reg];

    // pointer wrap and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: src/lar_norm.sv
// pipelined vector normalizer: band shift, sum of squares, bit-serial root, long divide
module lar_norm #(
    parameter int MAG_W     = 32,
    parameter int SIDE_W    = 1,
    parameter int FRAC_BITS = lar_pkg::DEF_FRAC_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [2:0]                in_neg,
    input  logic [2:0][MAG_W-1:0]     in_mag,
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_valid,
    output logic [2:0]                out_neg,
    output logic [2:0][FRAC_BITS:0]   out_mag,
    output logic [SIDE_W-1:0]         out_side
);
    import lar_pkg::*;

    localparam int EXT_W     = (MAG_W > MANT_W) ? MAG_W : MANT_W;
    localparam int POS_W     = $clog2(EXT_W);
    localparam int SQ_W      = 2 * MANT_W;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int REM_W     = ROOT_W + 3;
    localparam int DIV_STEPS = FRAC_BITS + 2;
    localparam int Q_W       = FRAC_BITS + 2;
    localparam int R_W       = ROOT_W + 1;
    localparam logic [POS_W-1:0] TOP_POS = POS_W'(MANT_W - 1);

    // stage 1: operands and or of magnitudes
    logic                  s1_valid_reg;
    logic [2:0]            s1_neg_reg;
    logic [2:0][MAG_W-1:0] s1_mag_reg;
    logic [MAG_W-1:0]      s1_or_reg;
    logic [SIDE_W-1:0]     s1_side_reg;

    // stage 2: leading-one position
    logic                  s2_valid_reg;
    logic [2:0]            s2_neg_reg;
    logic [2:0][MAG_W-1:0] s2_mag_reg;
    logic [POS_W-1:0]      s2_pos_reg, s2_pos_next;
    logic                  s2_zero_reg;
    logic [SIDE_W-1:0]     s2_side_reg;

    // stage 3: magnitudes shifted into the band
    logic                   s3_valid_reg;
    logic [2:0]             s3_neg_reg;
    logic [2:0][MANT_W-1:0] s3_mant_reg, s3_mant_next;
    logic [2:0][EXT_W-1:0]  s3_ext;
    logic                   s3_zero_reg;
    logic [SIDE_W-1:0]      s3_side_reg;

    // stage 4: squares
    logic                   s4_valid_reg;
    logic [2:0]             s4_neg_reg;
    logic [2:0][MANT_W-1:0] s4_mant_reg;
    logic [2:0][SQ_W-1:0]   s4_sq_reg;
    logic                   s4_zero_reg;
    logic [SIDE_W-1:0]      s4_side_reg;

    // square root line, index 0 holds the sum
    logic                   sq_valid_reg [SQ_STEPS+1];
    logic [SUM_W-1:0]       sq_s_reg     [SQ_STEPS+1];
    logic [REM_W-1:0]       sq_rem_reg   [SQ_STEPS+1];
    logic [ROOT_W-1:0]      sq_root_reg  [SQ_STEPS+1];
    logic [2:0][MANT_W-1:0] sq_mant_reg  [SQ_STEPS+1];
    logic [2:0]             sq_neg_reg   [SQ_STEPS+1];
    logic                   sq_zero_reg  [SQ_STEPS+1];
    logic [SIDE_W-1:0]      sq_side_reg  [SQ_STEPS+1];
    logic [REM_W-1:0]       sq_cur       [SQ_STEPS];
    logic [REM_W-1:0]       sq_trial     [SQ_STEPS];
    logic                   sq_take      [SQ_STEPS];

    // divide line, index 0 holds the loaded remainders
    logic                   dv_valid_reg [DIV_STEPS+1];
    logic [ROOT_W-1:0]      dv_n_reg     [DIV_STEPS+1];
    logic [2:0][ROOT_W-1:0] dv_r_reg     [DIV_STEPS+1];
    logic [2:0][Q_W-1:0]    dv_q_reg     [DIV_STEPS+1];
    logic [2:0]             dv_neg_reg   [DIV_STEPS+1];
    logic                   dv_zero_reg  [DIV_STEPS+1];
    logic [SIDE_W-1:0]      dv_side_reg  [DIV_STEPS+1];
    logic [2:0][R_W-1:0]    dv_t         [DIV_STEPS];
    logic [2:0]             dv_bit       [DIV_STEPS];

    // output register
    logic                    out_valid_reg;
    logic [2:0]              out_neg_reg;
    logic [2:0][FRAC_BITS:0] out_mag_reg, out_mag_next;
    logic [2:0][Q_W-1:0]     rnd;
    logic [SIDE_W-1:0]       out_side_reg;

    // leading one of the or word
    always_comb begin
        s2_pos_next = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (s1_or_reg[i]) begin
                s2_pos_next = POS_W'(i);
            end
        end
    end

    // shift so the largest magnitude lies in the band, right shifts truncate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s3_ext[k] = EXT_W'(s2_mag_reg[k]);
            if (s2_pos_reg >= TOP_POS) begin
                s3_ext[k] = s3_ext[k] >> (s2_pos_reg - TOP_POS);
            end else begin
                s3_ext[k] = s3_ext[k] << (TOP_POS - s2_pos_reg);
            end
            s3_mant_next[k] = s3_ext[k][MANT_W-1:0];
        end
    end

    // one root bit per stage
    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            sq_cur[k]   = {sq_rem_reg[k][REM_W-3:0], sq_s_reg[k][SUM_W-1-2*k -: 2]};
            sq_trial[k] = REM_W'({sq_root_reg[k], 2'b01});
            sq_take[k]  = sq_cur[k] >= sq_trial[k];
        end
    end

    // one quotient bit per lane per stage
    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            for (int j = 0; j < 3; j++) begin
                if (k == 0) begin
                    dv_t[k][j] = R_W'(dv_r_reg[k][j]);
                end else begin
                    dv_t[k][j] = {dv_r_reg[k][j], 1'b0};
                end
                dv_bit[k][j] = dv_t[k][j] >= R_W'(dv_n_reg[k]);
            end
        end
    end

    // round half up, zero vector stays zero
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            rnd[j]          = dv_q_reg[DIV_STEPS][j] + Q_W'(1);
            out_mag_next[j] = dv_zero_reg[DIV_STEPS] ? '0 : rnd[j][Q_W-1:1];
        end
    end

    // front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
        if (en) begin
            s1_neg_reg  <= in_neg;
            s1_mag_reg  <= in_mag;
            s1_or_reg   <= in_mag[0] | in_mag[1] | in_mag[2];
            s1_side_reg <= in_side;

            s2_neg_reg  <= s1_neg_reg;
            s2_mag_reg  <= s1_mag_reg;
            s2_pos_reg  <= s2_pos_next;
            s2_zero_reg <= s1_or_reg == '0;
            s2_side_reg <= s1_side_reg;

            s3_neg_reg  <= s2_neg_reg;
            s3_mant_reg <= s3_mant_next;
            s3_zero_reg <= s2_zero_reg;
            s3_side_reg <= s2_side_reg;

            s4_neg_reg  <= s3_neg_reg;
            s4_mant_reg <= s3_mant_reg;
            for (int k = 0; k < 3; k++) begin
                s4_sq_reg[k] <= SQ_W'(s3_mant_reg[k]) * SQ_W'(s3_mant_reg[k]);
            end
            s4_zero_reg <= s3_zero_reg;
            s4_side_reg <= s3_side_reg;
        end
    end

    // root line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= SQ_STEPS; k++) begin
                sq_valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            sq_valid_reg[0] <= s4_valid_reg;
            for (int k = 0; k < SQ_STEPS; k++) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end
        if (en) begin
            sq_s_reg[0]    <= SUM_W'(s4_sq_reg[0]) + SUM_W'(s4_sq_reg[1]) + SUM_W'(s4_sq_reg[2]);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_mant_reg[0] <= s4_mant_reg;
            sq_neg_reg[0]  <= s4_neg_reg;
            sq_zero_reg[0] <= s4_zero_reg;
            sq_side_reg[0] <= s4_side_reg;
            for (int k = 0; k < SQ_STEPS; k++) begin
                sq_s_reg[k+1]    <= sq_s_reg[k];
                sq_rem_reg[k+1]  <= sq_take[k] ? sq_cur[k] - sq_trial[k] : sq_cur[k];
                sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], sq_take[k]};
                sq_mant_reg[k+1] <= sq_mant_reg[k];
                sq_neg_reg[k+1]  <= sq_neg_reg[k];
                sq_zero_reg[k+1] <= sq_zero_reg[k];
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // divide line and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                dv_valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (en) begin
            dv_valid_reg[0] <= sq_valid_reg[SQ_STEPS];
            for (int k = 0; k < DIV_STEPS; k++) begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
            out_valid_reg <= dv_valid_reg[DIV_STEPS];
        end
        if (en) begin
            dv_n_reg[0] <= sq_root_reg[SQ_STEPS];
            for (int j = 0; j < 3; j++) begin
                dv_r_reg[0][j] <= ROOT_W'(sq_mant_reg[SQ_STEPS][j]);
            end
            dv_q_reg[0]    <= '0;
            dv_neg_reg[0]  <= sq_neg_reg[SQ_STEPS];
            dv_zero_reg[0] <= sq_zero_reg[SQ_STEPS];
            dv_side_reg[0] <= sq_side_reg[SQ_STEPS];
            for (int k = 0; k < DIV_STEPS; k++) begin
                dv_n_reg[k+1] <= dv_n_reg[k];
                for (int j = 0; j < 3; j++) begin
                    dv_r_reg[k+1][j] <= dv_bit[k][j]
                        ? ROOT_W'(dv_t[k][j] - R_W'(dv_n_reg[k])) : ROOT_W'(dv_t[k][j]);
                    dv_q_reg[k+1][j] <= {dv_q_reg[k][j][Q_W-2:0], dv_bit[k][j]};
                end
                dv_neg_reg[k+1]  <= dv_neg_reg[k];
                dv_zero_reg[k+1] <= dv_zero_reg[k];
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
            out_neg_reg  <= dv_neg_reg[DIV_STEPS];
            out_mag_reg  <= out_mag_next;
            out_side_reg <= dv_side_reg[DIV_STEPS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_neg   = out_neg_reg;
    assign out_mag   = out_mag_reg;
    assign out_side  = out_side_reg;

endmodule

FILE: src/lar_back.sv
// back end: ez, threshold test, ex, cross product, ey and the result register
module lar_back #(
    parameter int IN_WIDTH  = lar_pkg::DEF_IN_WIDTH,
    parameter int FRAC_BITS = lar_pkg::DEF_FRAC_BITS
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic [lar_pkg::THR_W-1:0]                threshold,
    input  logic                                     q_valid,
    output logic                                     q_pop,
    input  logic [2:0]                               q_neg,
    input  logic [2:0][IN_WIDTH-1:0]                 q_mag,
    input  logic                                     q_degen,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [lar_pkg::N_ENTRY*lar_pkg::OUT_W-1:0] m_data,
    output lar_pkg::lar_flags_t                      m_flags
);
    import lar_pkg::*;

    localparam int EZ_W     = FRAC_BITS + 1;
    localparam int EY_SHIFT = (FRAC_BITS > 30) ? FRAC_BITS - 30 : 0;
    localparam int AW       = EZ_W - EY_SHIFT;
    localparam int PM_W     = 2 * AW;
    localparam int D_W      = PM_W + 2;
    localparam int YM_W     = D_W - 1;
    localparam int CMP_W    = (EZ_W > THR_W) ? EZ_W : THR_W;
    localparam int TQ_W     = 2 * THR_W;
    localparam int VEC_W    = 3 + 3 * EZ_W;
    localparam int XS_W     = VEC_W + FLAG_W;
    localparam int YS_W     = 2 * VEC_W + FLAG_W;
    localparam int XO_W     = (EZ_W + 1 > OUT_W) ? EZ_W + 1 : OUT_W;

    logic en;

    // ez normalizer
    logic                   z_valid;
    logic [2:0]             z_neg;
    logic [2:0][EZ_W-1:0]   z_mag;
    logic                   z_degen;

    // threshold stage
    logic                   t_valid_reg;
    logic [2:0]             t_neg_reg;
    logic [2:0][EZ_W-1:0]   t_mag_reg;
    logic                   t_degen_reg;
    logic                   t_far_reg;
    logic [TQ_W-1:0]        t_sqx_reg, t_sqz_reg, t_thr_reg;
    logic [CMP_W-1:0]       cmp_x, cmp_z;
    logic                   alt;
    lar_flags_t             t_flags;
    logic [2:0]             c_neg;
    logic [2:0][EZ_W-1:0]   c_mag;

    // ex normalizer
    logic                   x_valid;
    logic [2:0]             x_neg;
    logic [2:0][EZ_W-1:0]   x_mag;
    logic [XS_W-1:0]        x_side;
    logic [2:0]             x_ez_neg;
    logic [2:0][EZ_W-1:0]   x_ez_mag;
    lar_flags_t             x_flags;

    // cross product stages
    logic [2:0][AW-1:0]     a_val, b_val;
    logic                   p_valid_reg;
    logic [5:0][PM_W-1:0]   p_mag_reg, p_mag_next;
    logic [5:0]             p_neg_reg, p_neg_next;
    logic [VEC_W-1:0]       p_ez_reg, p_ex_reg;
    lar_flags_t             p_flags_reg;
    logic signed [D_W-1:0]  d_term [6];
    logic                   d_valid_reg;
    logic signed [2:0][D_W-1:0] d_reg, d_next;
    logic [VEC_W-1:0]       d_ez_reg, d_ex_reg;
    lar_flags_t             d_flags_reg;
    logic [2:0]             c2_neg;
    logic [2:0][YM_W-1:0]   c2_mag;
    logic [D_W-1:0]         d_abs;

    // ey normalizer
    logic                   y_valid;
    logic [2:0]             y_neg;
    logic [2:0][EZ_W-1:0]   y_mag;
    logic [YS_W-1:0]        y_side;
    logic [2:0]             y_ez_neg, y_ex_neg;
    logic [2:0][EZ_W-1:0]   y_ez_mag, y_ex_mag;
    lar_flags_t             y_flags;

    // result register
    logic                              m_valid_reg;
    logic [N_ENTRY*OUT_W-1:0]          m_data_reg, m_data_next;
    lar_flags_t                        m_flags_reg;
    logic [N_ENTRY-1:0]                all_neg;
    logic [N_ENTRY-1:0][EZ_W-1:0]      all_mag;
    logic [N_ENTRY-1:0][XO_W-1:0]      all_ext;

    // the whole back pipeline advances while the result register can move
    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && q_valid;

    lar_norm #(
        .MAG_W    (IN_WIDTH),
        .SIDE_W   (1),
        .FRAC_BITS(FRAC_BITS)
    ) u_norm_z (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (q_pop),
        .in_neg   (q_neg),
        .in_mag   (q_mag),
        .in_side  (q_degen),
        .out_valid(z_valid),
        .out_neg  (z_neg),
        .out_mag  (z_mag),
        .out_side (z_degen)
    );

    // squares for the exact parallel test, only meaningful when both are below threshold
    assign cmp_x = CMP_W'(z_mag[0]);
    assign cmp_z = CMP_W'(z_mag[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_valid_reg <= 1'b0;
        end else if (en) begin
            t_valid_reg <= z_valid;
        end
        if (en) begin
            t_neg_reg   <= z_neg;
            t_mag_reg   <= z_mag;
            t_degen_reg <= z_degen;
            t_far_reg   <= (cmp_x >= CMP_W'(threshold)) || (cmp_z >= CMP_W'(threshold));
            t_sqx_reg   <= TQ_W'(cmp_x[THR_W-1:0]) * TQ_W'(cmp_x[THR_W-1:0]);
            t_sqz_reg   <= TQ_W'(cmp_z[THR_W-1:0]) * TQ_W'(cmp_z[THR_W-1:0]);
            t_thr_reg   <= TQ_W'(threshold) * TQ_W'(threshold);
        end
    end

    // pick the up vector and form up x ez
    always_comb begin
        alt = !t_degen_reg && !t_far_reg
            && ({1'b0, t_sqx_reg} + {1'b0, t_sqz_reg} < {1'b0, t_thr_reg});
        t_flags.degenerate        = t_degen_reg;
        t_flags.used_alternate_up = alt;
        if (alt) begin
            c_neg[0] = 1'b0;
            c_mag[0] = '0;
            c_neg[1] = !t_neg_reg[2];
            c_mag[1] = t_mag_reg[2];
            c_neg[2] = t_neg_reg[1];
            c_mag[2] = t_mag_reg[1];
        end else begin
            c_neg[0] = t_neg_reg[2];
            c_mag[0] = t_mag_reg[2];
            c_neg[1] = 1'b0;
            c_mag[1] = '0;
            c_neg[2] = !t_neg_reg[0];
            c_mag[2] = t_mag_reg[0];
        end
    end

    lar_norm #(
        .MAG_W    (EZ_W),
        .SIDE_W   (XS_W),
        .FRAC_BITS(FRAC_BITS)
    ) u_norm_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (t_valid_reg),
        .in_neg   (c_neg),
        .in_mag   (c_mag),
        .in_side  ({t_neg_reg, t_mag_reg, t_flags}),
        .out_valid(x_valid),
        .out_neg  (x_neg),
        .out_mag  (x_mag),
        .out_side (x_side)
    );

    assign {x_ez_neg, x_ez_mag, x_flags} = x_side;

    // truncated operands and the six partial products of ez x ex
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a_val[k] = AW'(x_ez_mag[k] >> EY_SHIFT);
            b_val[k] = AW'(x_mag[k] >> EY_SHIFT);
        end
        p_mag_next[0] = PM_W'(a_val[1]) * PM_W'(b_val[2]);
        p_neg_next[0] = x_ez_neg[1] ^ x_neg[2];
        p_mag_next[1] = PM_W'(a_val[2]) * PM_W'(b_val[1]);
        p_neg_next[1] = x_ez_neg[2] ^ x_neg[1];
        p_mag_next[2] = PM_W'(a_val[2]) * PM_W'(b_val[0]);
        p_neg_next[2] = x_ez_neg[2] ^ x_neg[0];
        p_mag_next[3] = PM_W'(a_val[0]) * PM_W'(b_val[2]);
        p_neg_next[3] = x_ez_neg[0] ^ x_neg[2];
        p_mag_next[4] = PM_W'(a_val[0]) * PM_W'(b_val[1]);
        p_neg_next[4] = x_ez_neg[0] ^ x_neg[1];
        p_mag_next[5] = PM_W'(a_val[1]) * PM_W'(b_val[0]);
        p_neg_next[5] = x_ez_neg[1] ^ x_neg[0];
    end

    // signed differences of the products
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            d_term[j] = p_neg_reg[j] ? -signed'(D_W'(p_mag_reg[j])) : signed'(D_W'(p_mag_reg[j]));
        end
        for (int k = 0; k < 3; k++) begin
            d_next[k] = d_term[2*k] - d_term[2*k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= x_valid;
            d_valid_reg <= p_valid_reg;
        end
        if (en) begin
            p_mag_reg   <= p_mag_next;
            p_neg_reg   <= p_neg_next;
            p_ez_reg    <= {x_ez_neg, x_ez_mag};
            p_ex_reg    <= {x_neg, x_mag};
            p_flags_reg <= x_flags;
            d_reg       <= d_next;
            d_ez_reg    <= p_ez_reg;
            d_ex_reg    <= p_ex_reg;
            d_flags_reg <= p_flags_reg;
        end
    end

    // sign and magnitude of the cross product
    always_comb begin
        d_abs = '0;
        for (int k = 0; k < 3; k++) begin
            c2_neg[k] = d_reg[k][D_W-1];
            d_abs     = d_reg[k][D_W-1] ? -d_reg[k] : d_reg[k];
            c2_mag[k] = d_abs[YM_W-1:0];
        end
    end

    lar_norm #(
        .MAG_W    (YM_W),
        .SIDE_W   (YS_W),
        .FRAC_BITS(FRAC_BITS)
    ) u_norm_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (d_valid_reg),
        .in_neg   (c2_neg),
        .in_mag   (c2_mag),
        .in_side  ({d_ez_reg, d_ex_reg, d_flags_reg}),
        .out_valid(y_valid),
        .out_neg  (y_neg),
        .out_mag  (y_mag),
        .out_side (y_side)
    );

    assign {y_ez_neg, y_ez_mag, y_ex_neg, y_ex_mag, y_flags} = y_side;

    // back to two's complement, rows ex, ey, ez
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            all_neg[k]     = y_ex_neg[k];
            all_mag[k]     = y_ex_mag[k];
            all_neg[3 + k] = y_neg[k];
            all_mag[3 + k] = y_mag[k];
            all_neg[6 + k] = y_ez_neg[k];
            all_mag[6 + k] = y_ez_mag[k];
        end
        for (int i = 0; i < N_ENTRY; i++) begin
            all_ext[i] = XO_W'(all_mag[i]);
            all_ext[i] = all_neg[i] ? -all_ext[i] : all_ext[i];
            m_data_next[i*OUT_W +: OUT_W] = all_ext[i][OUT_W-1:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= y_valid;
        end
        if (en) begin
            m_data_reg  <= m_data_next;
            m_flags_reg <= y_flags;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_flags = m_flags_reg;

endmodule
